// ===== hdl/assert_macros.svh =====
// Assertion macros used by the designer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bbd_pkg.sv =====
// Types, fixed-point constants and the CORDIC arctangent table of the biquad designer.
package bbd_pkg;

   localparam logic [31:0] Q30_PI      = 32'd3373259426;
   localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
   localparam logic signed [37:0] Q30_ONE_S = 38'sd1073741824;
   localparam int CORDIC_STEPS = 30;
   localparam int RESULT_LIMIT = 8;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_CHECK     = 12'b0000_0000_0010,
      ST_ANG_MUL   = 12'b0000_0000_0100,
      ST_ANG_DIV   = 12'b0000_0000_1000,
      ST_ROT       = 12'b0000_0001_0000,
      ST_PH_MUL    = 12'b0000_0010_0000,
      ST_PH_DIV    = 12'b0000_0100_0000,
      ST_ALPHA_MUL = 12'b0000_1000_0000,
      ST_ALPHA     = 12'b0001_0000_0000,
      ST_COEF      = 12'b0010_0000_0000,
      ST_EMIT      = 12'b0100_0000_0000,
      ST_SPARE     = 12'b1000_0000_0000
   } state_type;

   // atan(2^-i) in Q30 radians
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837830;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         5'd24: v = 32'd64;
         5'd25: v = 32'd32;
         5'd26: v = 32'd16;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/butterworth_biquad_designer.sv =====
// Butterworth cascade designer: one request gives the Q3.28 coefficients of every section.
// After a request is accepted, a bad request goes straight to its result beat; otherwise the
// first-order section (odd order), the setup of w0 and each biquad follow in turn, and each
// result beat waits while stalled. One request at a time, run on the shared 64-step radix-2
// divider, a 32-step shift-add multiplier and a 30-step CORDIC rotator.
// Synchronous active-high reset: idle, no result pending, sample rate back to 48000 Hz.
`include "assert_macros.svh"
module butterworth_biquad_designer #(
   parameter int MAX_ORDER      = 16,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [16:0]        req_cutoff_hz,
   input  logic [4:0]         req_filter_order,
   input  logic               req_filter_kind,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_section_index,
   output logic               rsp_is_first_order,
   output logic signed [31:0] rsp_coef_b0,
   output logic signed [31:0] rsp_coef_b1,
   output logic signed [31:0] rsp_coef_b2,
   output logic signed [31:0] rsp_coef_a1,
   output logic signed [31:0] rsp_coef_a2,
   output logic               rsp_last_section,
   output logic               rsp_bad_request,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [17:0]        csr_sample_rate_hz
);
   import bbd_pkg::*;

   state_type state_ff, state_in;
   logic go_ff;
   logic [17:0] fs_ff;
   logic [16:0] fc_ff;
   logic [4:0] ord_ff;
   logic hp_ff, bad_ff, sec_first_ff, ph_phase_ff, cneg_ff;
   logic [2:0] i_ff, k_ff;
   logic [1:0] cidx_ff;
   logic signed [33:0] sw_ff, cw_ff, rs_ff, rc_ff;
   logic signed [35:0] alpha_ff, alpha_in;
   logic signed [31:0] cb0_ff, cb1_ff, ca1_ff, ca2_ff;

   logic rsp_valid_ff, rsp_first_ff, rsp_last_ff, rsp_bad_ff;
   logic [2:0] rsp_idx_ff;
   logic signed [31:0] rsp_b0_ff, rsp_b1_ff, rsp_b2_ff, rsp_a1_ff, rsp_a2_ff;

   // shift-add multiplier
   logic [31:0] mul_a_ff, mul_a_in, mul_b_in;
   logic [63:0] mul_p_ff;
   logic [4:0] mul_cnt_ff;
   logic mul_run_ff, mul_done_ff, mul_start;
   logic [32:0] mul_sum;

   // restoring divider
   logic [63:0] div_n_ff, div_n_in;
   logic [34:0] div_r_ff, div_t;
   logic [33:0] div_d_ff, div_d_in;
   logic [5:0] div_cnt_ff;
   logic div_run_ff, div_done_ff, div_start, div_ge;

   // CORDIC rotator
   logic signed [33:0] rot_x_ff, rot_y_ff, rot_dx, rot_dy, rot_c;
   logic signed [32:0] rot_z_ff, rot_at;
   logic [4:0] rot_cnt_ff;
   logic rot_run_ff, rot_done_ff, rot_flip_ff, rot_start;
   logic [31:0] rot_ang;

   logic [3:0] nbiq;
   logic last_biq, bad_now, out_free, coef_last;
   logic signed [37:0] c_num, c_den_raw, a0, bnum;
   logic [37:0] c_mag_full;
   logic [33:0] c_den;
   logic [31:0] c_res;
   logic [33:0] sw_abs, rc_abs;
   logic signed [64:0] al_sv, al_t;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // decode the request
   assign nbiq      = ord_ff[4:1];
   assign last_biq  = ({1'b0, i_ff} == (nbiq - 4'd1));
   assign coef_last = sec_first_ff ? (cidx_ff == 2'd2) : (cidx_ff == 2'd3);
   assign bad_now   = (ord_ff == 5'd0) || ({1'b0, ord_ff} > 6'(MAX_ORDER)) ||
                      ((({1'b0, ord_ff} + 6'd1) >> 1) > 6'(RESULT_LIMIT)) ||
                      (fc_ff == 17'd0) || ({fc_ff, 1'b0} >= fs_ff);

   // pick numerator and denominator of the current coefficient
   always_comb begin
      a0   = Q30_ONE_S + 38'(alpha_ff);
      bnum = hp_ff ? (Q30_ONE_S + 38'(cw_ff)) : (Q30_ONE_S - 38'(cw_ff));
      if (sec_first_ff) begin
         c_den_raw = 38'(rs_ff) + 38'(rc_ff);
         case (cidx_ff)
            2'd0:    c_num = 38'(rs_ff) - 38'(rc_ff);
            2'd1:    c_num = hp_ff ? 38'(rc_ff) : 38'(rs_ff);
            default: c_num = hp_ff ? -38'(rc_ff) : 38'(rs_ff);
         endcase
      end else begin
         c_den_raw = (cidx_ff == 2'd0) ? (a0 <<< 1) : a0;
         case (cidx_ff)
            2'd0:    c_num = bnum;
            2'd1:    c_num = hp_ff ? -bnum : bnum;
            2'd2:    c_num = -(38'(cw_ff) <<< 1);
            default: c_num = Q30_ONE_S - 38'(alpha_ff);
         endcase
      end
      c_den      = (c_den_raw <= 38'sd0) ? 34'd1 : c_den_raw[33:0];
      c_mag_full = c_num[37] ? 38'(-c_num) : 38'(c_num);
   end

   // saturate the rounded quotient to 32 bits
   always_comb begin
      if (cneg_ff) begin
         c_res = (div_n_ff > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_n_ff[31:0]);
      end else begin
         c_res = (div_n_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_n_ff[31:0];
      end
   end

   // alpha = round(sw * cp) in Q30
   always_comb begin
      al_sv    = (sw_ff[33] ^ rc_ff[33]) ? -$signed({1'b0, mul_p_ff})
                                         : $signed({1'b0, mul_p_ff});
      al_t     = al_sv + 65'sd536870912;
      alpha_in = 36'(al_t >>> 30);
   end

   // unit operands
   always_comb begin
      sw_abs    = sw_ff[33] ? 34'(-sw_ff) : sw_ff;
      rc_abs    = rc_ff[33] ? 34'(-rc_ff) : rc_ff;
      mul_start = !go_ff && (state_ff == ST_ANG_MUL || state_ff == ST_PH_MUL ||
                             state_ff == ST_ALPHA_MUL);
      div_start = !go_ff && (state_ff == ST_ANG_DIV || state_ff == ST_PH_DIV ||
                             state_ff == ST_COEF);
      rot_start = !go_ff && (state_ff == ST_ROT);
      mul_a_in  = (state_ff == ST_ALPHA_MUL) ? rc_abs[31:0] : Q30_PI;
      case (state_ff)
         ST_ANG_MUL: mul_b_in = sec_first_ff ? {15'd0, fc_ff} : {14'd0, fc_ff, 1'b0};
         ST_PH_MUL:  mul_b_in = {28'd0, i_ff, 1'b1};
         default:    mul_b_in = sw_abs[31:0];
      endcase
      case (state_ff)
         ST_ANG_DIV: begin
            div_n_in = mul_p_ff + {47'd0, fs_ff[17:1]};
            div_d_in = {16'd0, fs_ff};
         end
         ST_PH_DIV: begin
            div_n_in = mul_p_ff + {59'd0, ord_ff};
            div_d_in = {28'd0, ord_ff, 1'b0};
         end
         default: begin
            div_n_in = ({28'd0, c_mag_full[35:0]} << COEF_FRAC_BITS) + {31'd0, c_den[33:1]};
            div_d_in = c_den;
         end
      endcase
   end

   // sequence the request
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK:     state_in = bad_now ? ST_EMIT : ST_ANG_MUL;
         ST_ANG_MUL:   if (mul_done_ff) state_in = ST_ANG_DIV;
         ST_ANG_DIV:   if (div_done_ff) state_in = ST_ROT;
         ST_ROT: begin
            if (rot_done_ff) begin
               if (sec_first_ff) state_in = ST_COEF;
               else if (!ph_phase_ff) state_in = ST_PH_MUL;
               else state_in = ST_ALPHA_MUL;
            end
         end
         ST_PH_MUL:    if (mul_done_ff) state_in = ST_PH_DIV;
         ST_PH_DIV:    if (div_done_ff) state_in = ST_ROT;
         ST_ALPHA_MUL: if (mul_done_ff) state_in = ST_ALPHA;
         ST_ALPHA:     state_in = ST_COEF;
         ST_COEF:      if (div_done_ff && coef_last) state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (bad_ff) state_in = ST_IDLE;
               else if (sec_first_ff) state_in = (nbiq == 4'd0) ? ST_IDLE : ST_ANG_MUL;
               else state_in = last_biq ? ST_IDLE : ST_PH_MUL;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control, captured values and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         fs_ff        <= 18'd48000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start || rot_start) go_ff <= 1'b1;
         else if (mul_done_ff || div_done_ff || rot_done_ff) go_ff <= 1'b0;
         if (csr_valid) fs_ff <= csr_sample_rate_hz;
         // hold the result beat until taken
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  fc_ff  <= req_cutoff_hz;
                  ord_ff <= req_filter_order;
                  hp_ff  <= req_filter_kind;
               end
            end
            ST_CHECK: begin
               bad_ff       <= bad_now;
               sec_first_ff <= ord_ff[0];
               ph_phase_ff  <= 1'b0;
               i_ff         <= 3'd0;
               k_ff         <= 3'd0;
               cidx_ff      <= 2'd0;
            end
            ST_ROT: begin
               if (rot_done_ff) begin
                  if (!sec_first_ff && !ph_phase_ff) begin
                     sw_ff       <= rot_y_ff;
                     cw_ff       <= rot_c;
                     ph_phase_ff <= 1'b1;
                  end else begin
                     rs_ff <= rot_y_ff;
                     rc_ff <= rot_c;
                  end
               end
            end
            ST_ALPHA: alpha_ff <= alpha_in;
            ST_COEF: begin
               if (div_start) cneg_ff <= c_num[37];
               if (div_done_ff) begin
                  cidx_ff <= cidx_ff + 2'd1;
                  case (cidx_ff)
                     2'd0: if (sec_first_ff) ca1_ff <= c_res; else cb0_ff <= c_res;
                     2'd1: if (sec_first_ff) cb0_ff <= c_res; else cb1_ff <= c_res;
                     2'd2: if (sec_first_ff) cb1_ff <= c_res; else ca1_ff <= c_res;
                     default: ca2_ff <= c_res;
                  endcase
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_idx_ff   <= bad_ff ? 3'd0 : k_ff;
                  rsp_first_ff <= !bad_ff && sec_first_ff;
                  rsp_bad_ff   <= bad_ff;
                  rsp_b0_ff    <= bad_ff ? 32'sd0 : cb0_ff;
                  rsp_b1_ff    <= bad_ff ? 32'sd0 : cb1_ff;
                  rsp_a1_ff    <= bad_ff ? 32'sd0 : ca1_ff;
                  rsp_b2_ff    <= (bad_ff || sec_first_ff) ? 32'sd0 : cb0_ff;
                  rsp_a2_ff    <= (bad_ff || sec_first_ff) ? 32'sd0 : ca2_ff;
                  if (bad_ff) rsp_last_ff <= 1'b1;
                  else if (sec_first_ff) rsp_last_ff <= (nbiq == 4'd0);
                  else rsp_last_ff <= last_biq;
                  k_ff    <= k_ff + 3'd1;
                  cidx_ff <= 2'd0;
                  if (sec_first_ff) sec_first_ff <= 1'b0;
                  else i_ff <= i_ff + 3'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // multiply: one multiplier bit per cycle
   assign mul_sum = {1'b0, mul_p_ff[63:32]} + (mul_p_ff[0] ? {1'b0, mul_a_ff} : 33'd0);
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_run_ff  <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= !mul_start && mul_run_ff && (mul_cnt_ff == 5'd31);
         if (mul_start) begin
            mul_a_ff   <= mul_a_in;
            mul_p_ff   <= {32'd0, mul_b_in};
            mul_cnt_ff <= 5'd0;
            mul_run_ff <= 1'b1;
         end else if (mul_run_ff) begin
            mul_p_ff   <= {mul_sum, mul_p_ff[31:1]};
            mul_cnt_ff <= mul_cnt_ff + 5'd1;
            if (mul_cnt_ff == 5'd31) mul_run_ff <= 1'b0;
         end
      end
   end

   // divide: one quotient bit per cycle
   assign div_t  = {div_r_ff[33:0], div_n_ff[63]};
   assign div_ge = (div_t >= {1'b0, div_d_ff});
   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff  <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= !div_start && div_run_ff && (div_cnt_ff == 6'd63);
         if (div_start) begin
            div_n_ff   <= div_n_in;
            div_d_ff   <= div_d_in;
            div_r_ff   <= 35'd0;
            div_cnt_ff <= 6'd0;
            div_run_ff <= 1'b1;
         end else if (div_run_ff) begin
            div_r_ff   <= div_ge ? (div_t - {1'b0, div_d_ff}) : div_t;
            div_n_ff   <= {div_n_ff[62:0], div_ge};
            div_cnt_ff <= div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) div_run_ff <= 1'b0;
         end
      end
   end

   // rotate: one CORDIC step per cycle, angles above pi/2 reflected
   assign rot_ang = div_n_ff[31:0];
   assign rot_dx  = rot_y_ff >>> rot_cnt_ff;
   assign rot_dy  = rot_x_ff >>> rot_cnt_ff;
   assign rot_at  = $signed({1'b0, atan_q30(rot_cnt_ff)});
   assign rot_c   = rot_flip_ff ? -rot_x_ff : rot_x_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_run_ff  <= 1'b0;
         rot_done_ff <= 1'b0;
      end else begin
         rot_done_ff <= !rot_start && rot_run_ff && (rot_cnt_ff == 5'(CORDIC_STEPS - 1));
         if (rot_start) begin
            rot_flip_ff <= (rot_ang > Q30_HALF_PI);
            rot_z_ff    <= (rot_ang > Q30_HALF_PI) ? $signed({1'b0, Q30_PI - rot_ang})
                                                   : $signed({1'b0, rot_ang});
            rot_x_ff    <= $signed({2'b00, CORDIC_GAIN});
            rot_y_ff    <= 34'sd0;
            rot_cnt_ff  <= 5'd0;
            rot_run_ff  <= 1'b1;
         end else if (rot_run_ff) begin
            if (!rot_z_ff[32]) begin
               rot_x_ff <= rot_x_ff - rot_dx;
               rot_y_ff <= rot_y_ff + rot_dy;
               rot_z_ff <= rot_z_ff - rot_at;
            end else begin
               rot_x_ff <= rot_x_ff + rot_dx;
               rot_y_ff <= rot_y_ff - rot_dy;
               rot_z_ff <= rot_z_ff + rot_at;
            end
            rot_cnt_ff <= rot_cnt_ff + 5'd1;
            if (rot_cnt_ff == 5'(CORDIC_STEPS - 1)) rot_run_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_section_index  = rsp_idx_ff;
   assign rsp_is_first_order = rsp_first_ff;
   assign rsp_coef_b0        = rsp_b0_ff;
   assign rsp_coef_b1        = rsp_b1_ff;
   assign rsp_coef_b2        = rsp_b2_ff;
   assign rsp_coef_a1        = rsp_a1_ff;
   assign rsp_coef_a2        = rsp_a2_ff;
   assign rsp_last_section   = rsp_last_ff;
   assign rsp_bad_request    = rsp_bad_ff;

   // checks
   `ASSERT_IMPLIES(a_bad_beat_empty, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_last_ff && rsp_b0_ff == 32'sd0 && rsp_a1_ff == 32'sd0 && !rsp_first_ff)
   `ASSERT_IMPLIES(a_first_order_shape, clock, reset, rsp_valid_ff && rsp_first_ff, rsp_idx_ff == 3'd0 && rsp_b2_ff == 32'sd0 && rsp_a2_ff == 32'sd0)
   `ASSERT_IMPLIES(a_one_unit_busy, clock, reset, 1'b1, $countones({mul_run_ff, div_run_ff, rot_run_ff}) <= 1)
   `ASSERT_NEXT(a_issue_clears, clock, reset, mul_done_ff || div_done_ff || rot_done_ff, !go_ff)

endmodule
